// ===== hdl/gms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gms_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_WREAD,
    ST_WDATA,
    ST_WDIV,
    ST_WSQUARE,
    ST_WACC,
    ST_ESTART,
    ST_EDIV,
    ST_PENALTY,
    ST_FINISH,
    ST_EMIT
  } gms_state_t;

  localparam logic [15:0]        RES_RESET = 16'd4096;
  localparam logic [31:0]        SUM_CAP   = 32'hFFFF_FFFF;
  localparam logic signed [23:0] Q_MAX     = 24'sh7F_FFFF;
  localparam logic signed [23:0] Q_MIN     = -24'sh80_0000;
  localparam logic [2:0]         ADDR_RESOLUTION = 3'd0;
  localparam int                 SHARE_BITS = 17;

endpackage

`default_nettype wire

// ===== hdl/gms_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] node_community;
  logic [7:0] neighbor_community;
  logic [15:0] edge_weight;
  logic       last_entry;

  modport source (output valid, node_community, neighbor_community, edge_weight,
                  last_entry, input ready);
  modport sink   (input valid, node_community, neighbor_community, edge_weight,
                  last_entry, output ready);
endinterface

interface gms_out_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] modularity;
  logic              empty_graph;

  modport source (output valid, modularity, empty_graph, input ready);
  modport sink   (input valid, modularity, empty_graph, output ready);
endinterface

`default_nettype wire

// ===== hdl/gms_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, quotient assumed below 2^steps.
module gms_div #(
  parameter int NW = 66,
  parameter int DW = 33,
  parameter int QW = 65,
  parameter int KW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [KW-1:0] steps,
  output logic               done,
  output logic [QW-1:0]      quot
);

  localparam int SW = DW + QW;
  localparam int MW = (NW > SW) ? NW : SW;

  logic [NW-1:0] rem_r;
  logic [SW-1:0] dsh_r;
  logic [QW-1:0] quot_r;
  logic [KW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic          ge;
  logic [MW-1:0] diff;

  assign ge   = MW'(rem_r) >= MW'(dsh_r);
  assign diff = MW'(rem_r) - MW'(dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == KW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      dsh_r  <= SW'(den) << (steps - KW'(1));
      quot_r <= '0;
      cnt_r  <= steps;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= NW'(diff);
      end
      quot_r <= {quot_r[QW-2:0], ge};
      dsh_r  <= dsh_r >> 1;
      cnt_r  <= cnt_r - KW'(1);
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// ===== hdl/graph_modularity_score_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Loading: each adjacency transaction reads, then writes back, one community word. Final
// entry: walk of COMMUNITIES words, each through WREAD, WDATA, the 17-step share divider,
// WSQUARE and WACC, then a quotient of 32+log2(COMMUNITIES)+17 steps and the PENALTY and
// FINISH states to the result register. Reset (rst_n low, synchronous) clears control state
// and then sweeps the community memory to zero, during which no input transaction is taken.
module graph_modularity_score_top
  import gms_pkg::*;
#(
  parameter int COMMUNITIES = 256,
  parameter int MAX_ENTRIES = 65536,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gms_in_if.sink           in_ch,
  gms_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW  = (COMMUNITIES > 1) ? $clog2(COMMUNITIES) : 1;
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int ISW = 32 + CW;             // sum of internal weights
  localparam int QW  = ISW + 17;            // quotient width for the internal share
  localparam int NW  = ISW + 18;            // dividend width
  localparam int KW  = $clog2(QW + 1);
  localparam logic [CW-1:0]  LAST_IDX = CW'(COMMUNITIES - 1);
  localparam logic [ECW-1:0] ENT_MAX  = ECW'(MAX_ENTRIES);
  localparam logic [15:0]    WMASK    =
    (WEIGHT_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << WEIGHT_BITS) - 64'd1);

  gms_state_t state_r, state_nxt;

  // community memory: {degree sum, internal sum}
  logic [63:0]   mem [COMMUNITIES];
  logic [63:0]   rdata_r;
  logic [CW-1:0] rd_addr;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  logic [CW-1:0]  widx_r;
  logic [31:0]    s_r;
  logic [ECW-1:0] cnt_r;
  logic [CW-1:0]  nc_r;
  logic           same_r;
  logic [15:0]    w_r;
  logic           last_r;
  logic           ok_r;
  logic [47:0]    acc_r;
  logic [ISW-1:0] isum_r;
  logic [16:0]    p_r;
  logic [33:0]    sq_r;
  logic [QW-1:0]  e_r;
  logic [35:0]    pen_r;
  logic [23:0]    q_r;
  logic           empty_r;
  logic [15:0]    res_r;
  logic           out_valid_r;
  logic [23:0]    out_q_r;
  logic           out_empty_r;

  logic           in_take;
  logic           emit_go;
  logic [15:0]    w_in;
  logic [32:0]    s_sum;
  logic [32:0]    deg_sum;
  logic [32:0]    int_sum;
  logic [31:0]    deg_new;
  logic [31:0]    int_new;

  logic           div_start;
  logic [NW-1:0]  div_num;
  logic [KW-1:0]  div_steps;
  logic           div_done;
  logic [QW-1:0]  div_quot;

  logic signed [QW+1:0] diff;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RESOLUTION) ? {16'd0, res_r} : 32'd0;

  assign in_take = in_ch.valid && in_ch.ready;
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign w_in    = in_ch.edge_weight & WMASK;
  assign s_sum   = {1'b0, s_r} + 33'(w_in);

  // read-modify-write arithmetic on the fetched community word
  assign deg_sum = {1'b0, rdata_r[63:32]} + 33'(w_r);
  assign int_sum = {1'b0, rdata_r[31:0]} + 33'(w_r);
  assign deg_new = deg_sum[32] ? SUM_CAP : deg_sum[31:0];
  assign int_new = !same_r ? rdata_r[31:0] : (int_sum[32] ? SUM_CAP : int_sum[31:0]);

  assign diff = signed'({2'b00, e_r}) - signed'((QW+2)'(pen_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (widx_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_take) state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (s_r == 32'd0) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_WREAD;
        end
      end
      ST_WREAD:   state_nxt = ST_WDATA;
      ST_WDATA:   state_nxt = ST_WDIV;
      ST_WDIV:    if (div_done) state_nxt = ST_WSQUARE;
      ST_WSQUARE: state_nxt = ST_WACC;
      ST_WACC:    state_nxt = (widx_r == LAST_IDX) ? ST_ESTART : ST_WREAD;
      ST_ESTART:  state_nxt = ST_EDIV;
      ST_EDIV:    if (div_done) state_nxt = ST_PENALTY;
      ST_PENALTY: state_nxt = ST_FINISH;
      ST_FINISH:  state_nxt = ST_EMIT;
      ST_EMIT:    if (emit_go) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    rd_addr     = widx_r;
    mem_we      = 1'b0;
    mem_waddr   = widx_r;
    mem_wdata   = 64'd0;
    div_start   = 1'b0;
    div_num     = NW'({rdata_r[63:32], 17'd0}) + NW'(s_r);
    div_steps   = KW'(SHARE_BITS);
    case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = CW'(in_ch.node_community);
      end
      ST_UPDATE: begin
        mem_we    = ok_r;
        mem_waddr = nc_r;
        mem_wdata = {deg_new, int_new};
      end
      ST_WDATA: begin
        mem_we    = 1'b1;   // clear behind the walk
        div_start = 1'b1;
      end
      ST_ESTART: begin
        div_start = 1'b1;
        div_num   = NW'({isum_r, 17'd0}) + NW'(s_r);
        div_steps = KW'(QW);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  gms_div #(
    .NW(NW),
    .DW(33),
    .QW(QW),
    .KW(KW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   ({s_r, 1'b0}),
    .steps (div_steps),
    .done  (div_done),
    .quot  (div_quot)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      widx_r      <= '0;
      s_r         <= 32'd0;
      cnt_r       <= '0;
      acc_r       <= 48'd0;
      isum_r      <= '0;
      res_r       <= RES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && paddr == ADDR_RESOLUTION) begin
        res_r <= pwdata[15:0];
      end
      case (state_r)
        ST_CLEAR: widx_r <= (widx_r == LAST_IDX) ? '0 : widx_r + CW'(1);
        ST_IDLE: begin
          if (in_take && cnt_r < ENT_MAX) begin
            cnt_r <= cnt_r + ECW'(1);
            s_r   <= s_sum[32] ? SUM_CAP : s_sum[31:0];
          end
        end
        ST_WDATA: isum_r <= isum_r + ISW'(rdata_r[31:0]);
        ST_WACC: begin
          acc_r  <= acc_r + 48'(sq_r);
          widx_r <= (widx_r == LAST_IDX) ? '0 : widx_r + CW'(1);
        end
        ST_EMIT: begin
          if (emit_go) begin
            s_r    <= 32'd0;
            cnt_r  <= '0;
            acc_r  <= 48'd0;
            isum_r <= '0;
          end
        end
        default: ;
      endcase
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      nc_r   <= CW'(in_ch.node_community);
      same_r <= in_ch.node_community == in_ch.neighbor_community;
      w_r    <= w_in;
      last_r <= in_ch.last_entry;
      ok_r   <= (cnt_r < ENT_MAX) && (32'(in_ch.node_community) < 32'(COMMUNITIES));
    end
    if (state_r == ST_UPDATE) begin
      q_r     <= 24'd0;
      empty_r <= 1'b1;
    end
    if (state_r == ST_WDIV && div_done) begin
      p_r <= div_quot[16:0];
    end
    if (state_r == ST_WSQUARE) begin
      sq_r <= p_r * p_r;
    end
    if (state_r == ST_EDIV && div_done) begin
      e_r <= div_quot;
    end
    if (state_r == ST_PENALTY) begin
      pen_r <= 36'((64'(acc_r) * 64'(res_r) + 64'h800_0000) >> 28);
    end
    if (state_r == ST_FINISH) begin
      empty_r <= 1'b0;
      if (diff > (QW+2)'(Q_MAX)) begin
        q_r <= Q_MAX;
      end else if (diff < (QW+2)'(Q_MIN)) begin
        q_r <= Q_MIN;
      end else begin
        q_r <= diff[23:0];
      end
    end
    if (emit_go) begin
      out_q_r     <= q_r;
      out_empty_r <= empty_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.modularity  = out_q_r;
  assign out_ch.empty_graph = out_empty_r;

endmodule

`default_nettype wire
